### hdl/dfr_pkg.sv
// Shared types and constants for the box and NAL length deframer.
package dfr_pkg;

  localparam logic [31:0] NAL_TYPE_RESET = 32'h6D64_6174;  // 'mdat'
  localparam logic [31:0] BOX_HDR_BYTES  = 32'd8;
  localparam logic [31:0] NAL_LEN_BYTES  = 32'd4;
  localparam int unsigned QUEUE_DEPTH    = 2;

  typedef enum logic [2:0] {
    KIND_BOX_HDR = 3'd0,
    KIND_BOX_PAY = 3'd1,
    KIND_NAL_LEN = 3'd2,
    KIND_NAL_PAY = 3'd3,
    KIND_PAD     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_BOX_SIZE  = 2'd1,
    ERR_NAL_OVER  = 2'd2,
    ERR_SHORT_PFX = 2'd3
  } err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  byte_value;
    kind_e       byte_kind;
    logic [31:0] current_box_type;
    logic [31:0] box_bytes_left;
    logic [31:0] nal_bytes_left;
    logic        box_header_done;
    logic        nal_header_done;
    logic        box_last;
    logic        nal_last;
    err_e        error_code;
  } out_item_t;

  typedef logic [31:0] cfg_word_t;

  // Handshake between the parser and the result queue.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } push_t;

endpackage

### hdl/dfr_in_if.sv
// Byte input channel: valid/ready with one file byte per beat.
interface dfr_in_if;
  import dfr_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hdl/dfr_out_if.sv
// Result channel: valid/ready with one classified byte per beat.
interface dfr_out_if;
  import dfr_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hdl/dfr_cfg_if.sv
// Configuration write channel: container box type word.
interface dfr_cfg_if;
  import dfr_pkg::*;
  logic      valid;
  logic      ready;
  cfg_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hdl/box_and_nal_length_deframer.sv
// Top level of the box and NAL length deframer.
//
// Takes a file one byte per beat on in_i and returns one result beat per byte
// on out_o, in order. Top-level boxes (32-bit big-endian size, 32-bit type)
// are walked and their payload counted off; inside a box whose type equals the
// container type written on cfg_i (reset 'mdat'), the payload is split into
// NAL units with 4-byte big-endian length prefixes. Each result carries the
// byte, its kind, the current box type, the bytes left in box and NAL, and
// start/end markers. Repairs are flagged in error_code: a box size below 8
// becomes a header-only box, a NAL length past the end of the box is clamped,
// and fewer than 4 bytes left for a NAL prefix are passed as padding. A byte
// with file_start set restarts the parser on it; the container type is kept.
// Throughput is one byte per clock while the result queue has room: all
// per-byte work (shift, compare, decrement) is combinational in the parser.
// A result is queued as its byte is accepted. A two-beat result queue
// decouples the sides; in_i.ready drops only while two results wait. cfg_i
// is always ready and must be written only while the block is idle.
module box_and_nal_length_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  dfr_in_if.sink      in_i,
  dfr_out_if.source   out_o,
  dfr_cfg_if.sink     cfg_i
);
  import dfr_pkg::*;

  logic [31:0] nal_type_q;   // container box type
  push_t       push;         // parser result toward the queue
  logic        queue_ready;

  // configuration register, one write per beat
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nal_type_q <= NAL_TYPE_RESET;
    end else if (cfg_i.valid) begin
      nal_type_q <= cfg_i.payload;
    end
  end

  // front end: parse state machine, one byte per cycle while the queue has room
  dfr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_item_i     (in_i.payload),
    .in_ready_o    (in_i.ready),
    .nal_type_i    (nal_type_q),
    .queue_ready_i (queue_ready),
    .push_o        (push)
  );

  // back end: result queue drives the output channel
  dfr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .ready_o     (queue_ready),
    .valid_o     (out_o.valid),
    .item_o      (out_o.payload),
    .pop_ready_i (out_o.ready)
  );

  // an accepted byte always has a result waiting next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> out_o.valid)
    else $error("accepted byte produced no result");

  // input backpressure only while results are pending
  a_stall_has_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled with empty queue");

  // header-done flags only on the matching byte kinds; a NAL header sets nal_last exactly when its length is zero
  a_box_hdr_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.payload.box_header_done) |->
      (out_o.payload.byte_kind == KIND_BOX_HDR))
    else $error("box header done on non-header byte");

  a_nal_hdr_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.payload.nal_header_done) |->
      (out_o.payload.byte_kind == KIND_NAL_LEN && out_o.payload.nal_last ==
       (out_o.payload.nal_bytes_left == 32'd0)))
    else $error("NAL header done inconsistent");

endmodule

### hdl/dfr_front.sv
// Parser front end: classifies each accepted byte and tracks box/NAL counters.
module dfr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  dfr_pkg::in_item_t in_item_i,
  output logic              in_ready_o,
  input  logic [31:0]       nal_type_i,
  input  logic              queue_ready_i,
  output dfr_pkg::push_t    push_o
);
  import dfr_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR  = 3'd0,
    PH_PAY  = 3'd1,
    PH_NLEN = 3'd2,
    PH_NPAY = 3'd3,
    PH_PAD  = 3'd4
  } phase_e;

  phase_e      phase_q, phase_d, ph;
  logic [31:0] shift_q, shift_d, shift_c, shift_sh;
  logic [2:0]  cnt_q, cnt_d, cnt_c, cnt_inc;
  logic [31:0] btype_q, btype_d, btype_c;
  logic [31:0] brem_q, brem_d, brem_c, brem_dec, brem_new;
  logic [31:0] nrem_q, nrem_d, nrem_c, nrem_dec, nal_len;
  logic        innal_q, innal_d, innal_c, innal_new;
  logic        accept;
  out_item_t   res;

  assign in_ready_o = queue_ready_i;
  assign accept     = in_valid_i & queue_ready_i;

  always_comb begin
    // file_start clears the parse state before this byte is used
    ph      = phase_q;
    shift_c = shift_q;
    cnt_c   = cnt_q;
    btype_c = btype_q;
    brem_c  = brem_q;
    nrem_c  = nrem_q;
    innal_c = innal_q;
    if (in_item_i.file_start) begin
      ph      = PH_HDR;
      shift_c = '0;
      cnt_c   = '0;
      btype_c = '0;
      brem_c  = '0;
      nrem_c  = '0;
      innal_c = 1'b0;
    end
    if (ph == PH_NLEN && cnt_c == 3'd0 && brem_c < NAL_LEN_BYTES) begin
      ph = PH_PAD;
    end

    shift_sh  = {shift_c[23:0], in_item_i.data_byte};
    cnt_inc   = cnt_c + 3'd1;
    brem_dec  = brem_c - 32'd1;
    nrem_dec  = nrem_c - 32'd1;
    nal_len   = shift_sh;
    brem_new  = '0;
    innal_new = 1'b0;

    phase_d = ph;
    shift_d = shift_c;
    cnt_d   = cnt_c;
    btype_d = btype_c;
    brem_d  = brem_c;
    nrem_d  = nrem_c;
    innal_d = innal_c;

    res                 = '0;
    res.byte_value      = in_item_i.data_byte;
    res.byte_kind       = KIND_BOX_HDR;
    res.error_code      = ERR_NONE;

    unique case (ph)
      PH_PAY, PH_PAD: begin
        res.byte_kind      = (ph == PH_PAY) ? KIND_BOX_PAY : KIND_PAD;
        res.error_code     = (ph == PH_PAY) ? ERR_NONE : ERR_SHORT_PFX;
        brem_d             = brem_dec;
        res.box_bytes_left = brem_dec;
        if (brem_dec == 32'd0) begin
          res.box_last = 1'b1;
          phase_d      = PH_HDR;
        end
      end
      PH_NLEN: begin
        res.byte_kind      = KIND_NAL_LEN;
        shift_d            = shift_sh;
        cnt_d              = cnt_inc;
        brem_d             = brem_dec;
        res.box_bytes_left = brem_dec;
        if (cnt_inc == 3'd4) begin
          cnt_d               = 3'd0;
          res.nal_header_done = 1'b1;
          if (shift_sh > brem_dec) begin
            nal_len        = brem_dec;
            res.error_code = ERR_NAL_OVER;
          end
          nrem_d             = nal_len;
          res.nal_bytes_left = nal_len;
          if (nal_len == 32'd0) begin
            res.nal_last = 1'b1;
            if (brem_dec == 32'd0) begin
              res.box_last = 1'b1;
              phase_d      = PH_HDR;
            end else begin
              phase_d = PH_NLEN;
            end
          end else begin
            phase_d = PH_NPAY;
          end
        end
      end
      PH_NPAY: begin
        res.byte_kind      = KIND_NAL_PAY;
        nrem_d             = nrem_dec;
        brem_d             = brem_dec;
        res.nal_bytes_left = nrem_dec;
        res.box_bytes_left = brem_dec;
        if (nrem_dec == 32'd0) begin
          res.nal_last = 1'b1;
          if (brem_dec == 32'd0) begin
            res.box_last = 1'b1;
            phase_d      = PH_HDR;
          end else begin
            phase_d = PH_NLEN;
          end
        end
      end
      default: begin
        // box header, also unused phase codes
        phase_d = PH_HDR;
        shift_d = shift_sh;
        cnt_d   = cnt_inc;
        if (cnt_inc == 3'd4) begin
          brem_d = shift_sh;
        end else if (cnt_inc == 3'd0) begin
          btype_d             = shift_sh;
          res.box_header_done = 1'b1;
          innal_new           = (shift_sh == nal_type_i);
          innal_d             = innal_new;
          if (brem_c < BOX_HDR_BYTES) begin
            res.error_code = ERR_BOX_SIZE;
            brem_new       = '0;
          end else begin
            brem_new = brem_c - BOX_HDR_BYTES;
          end
          brem_d             = brem_new;
          res.box_bytes_left = brem_new;
          if (brem_new == 32'd0) begin
            res.box_last = 1'b1;
            phase_d      = PH_HDR;
          end else if (innal_new) begin
            phase_d = PH_NLEN;
          end else begin
            phase_d = PH_PAY;
          end
        end
      end
    endcase

    res.current_box_type = btype_d;
  end

  assign push_o.valid = accept;
  assign push_o.item  = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR;
      shift_q <= '0;
      cnt_q   <= '0;
      btype_q <= '0;
      brem_q  <= '0;
      nrem_q  <= '0;
      innal_q <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      cnt_q   <= cnt_d;
      btype_q <= btype_d;
      brem_q  <= brem_d;
      nrem_q  <= nrem_d;
      innal_q <= innal_d;
    end
  end

endmodule

### hdl/dfr_queue.sv
// Two-entry result queue between the parser and the output channel.
module dfr_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dfr_pkg::push_t      push_i,
  output logic                ready_o,
  output logic                valid_o,
  output dfr_pkg::out_item_t  item_o,
  input  logic                pop_ready_i
);
  import dfr_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  out_item_t       mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign ready_o = (count_q != CntW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign push    = push_i.valid & ready_o;
  assign pop     = valid_o & pop_ready_i;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

endmodule
